// ----- rtl/dhslc_pkg.sv -----
// ----------------------------------------------------------------------------
// dhslc_pkg
// Shared types and constants for the high-pass / high-pass / low-pass chain.
// ----------------------------------------------------------------------------
package dhslc_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned FRAC_W   = 16;
  // Difference operand: last_out + x - last_in needs two extra bits.
  localparam int unsigned OPND_W   = SAMPLE_W + 2;
  // Signed product plus the low-pass feed term, with headroom.
  localparam int unsigned PROD_W   = OPND_W + COEF_W + 1;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COEF_W-1:0] HP1_COEF_RST = 16'd65408;
  localparam logic [COEF_W-1:0] HP2_COEF_RST = 16'd62470;
  localparam logic [COEF_W-1:0] LP_COEF_RST  = 16'd63343;

  localparam logic [CFG_IDX_W-1:0] REG_HP1_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP2_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_COEF  = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SUM,
    OP_DIFF,
    OP_MUL,
    OP_RND,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    SEL_HP1,
    SEL_HP2,
    SEL_LP
  } sel_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_OUT_FULL,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    op_e               op;
    sel_e              sel;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic out_full;
  } status_t;

endpackage

// ----- rtl/dhslc_seq.sv -----
// ----------------------------------------------------------------------------
// dhslc_seq
// Step counter and microcode ROM that drive the filter datapath.
// ----------------------------------------------------------------------------
module dhslc_seq
  import dhslc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SUM1 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;

  function automatic ctrl_t rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, sel: SEL_HP1, cond: COND_NEVER, target: STEP_WAIT};
    unique case (step)
      4'd0:  w = '{op: OP_LOAD, sel: SEL_HP1, cond: COND_NO_IN,    target: STEP_WAIT};
      4'd1:  w = '{op: OP_SUM,  sel: SEL_HP1, cond: COND_NEVER,    target: STEP_WAIT};
      4'd2:  w = '{op: OP_MUL,  sel: SEL_HP1, cond: COND_NEVER,    target: STEP_WAIT};
      4'd3:  w = '{op: OP_RND,  sel: SEL_HP1, cond: COND_NEVER,    target: STEP_WAIT};
      4'd4:  w = '{op: OP_SUM,  sel: SEL_HP2, cond: COND_NEVER,    target: STEP_WAIT};
      4'd5:  w = '{op: OP_MUL,  sel: SEL_HP2, cond: COND_NEVER,    target: STEP_WAIT};
      4'd6:  w = '{op: OP_RND,  sel: SEL_HP2, cond: COND_NEVER,    target: STEP_WAIT};
      4'd7:  w = '{op: OP_DIFF, sel: SEL_LP,  cond: COND_NEVER,    target: STEP_WAIT};
      4'd8:  w = '{op: OP_MUL,  sel: SEL_LP,  cond: COND_NEVER,    target: STEP_WAIT};
      4'd9:  w = '{op: OP_RND,  sel: SEL_LP,  cond: COND_NEVER,    target: STEP_WAIT};
      4'd10: w = '{op: OP_EMIT, sel: SEL_LP,  cond: COND_OUT_FULL, target: STEP_EMIT};
      default: w = '{op: OP_NOP, sel: SEL_HP1, cond: COND_ALWAYS,  target: STEP_WAIT};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] pc_q, pc_d;
  logic              jump;

  assign ctrl_o = rom(pc_q);

  always_comb begin
    unique case (ctrl_o.cond)
      COND_NO_IN:    jump = !status_i.in_accept;
      COND_OUT_FULL: jump = status_i.out_full;
      COND_ALWAYS:   jump = 1'b1;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? ctrl_o.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= STEP_LAST)
    else $error("step counter left the program");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.in_accept |=> pc_q == STEP_SUM1)
    else $error("accepted transaction did not start the program");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_EMIT && status_i.out_full) |=> pc_q == STEP_EMIT)
    else $error("program moved on while the output register was full");

  a_accept_only_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.in_accept |-> pc_q == STEP_WAIT)
    else $error("input accepted outside the wait step");

endmodule

// ----- rtl/dhslc_dp.sv -----
// ----------------------------------------------------------------------------
// dhslc_dp
// Filter datapath: operand adder, shared multiplier, round and saturate,
// filter state and output register.
// ----------------------------------------------------------------------------
module dhslc_dp
  import dhslc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic                       load_i,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic [COEF_W-1:0]          hp1_coef_i,
  input  logic [COEF_W-1:0]          hp2_coef_i,
  input  logic [COEF_W-1:0]          lp_coef_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic                       out_full_o,
  output logic signed [SAMPLE_W-1:0] out_sample_o
);

  localparam int unsigned RES_W = PROD_W - FRAC_W;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [OPND_W-1:0]   a_q;
  logic signed [PROD_W-1:0]   p_q;
  logic signed [SAMPLE_W-1:0] s1_in_q, s1_out_q, s2_in_q, s2_out_q, mem_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       out_valid_q;

  logic [COEF_W-1:0]          coef_c;
  logic signed [SAMPLE_W-1:0] last_in_c, last_out_c;
  logic signed [OPND_W-1:0]   opnd_c;
  logic signed [COEF_W:0]     coef_s;
  logic signed [PROD_W-1:0]   prod_c, base_c, rnd_c;
  logic signed [RES_W-1:0]    res_c;
  logic signed [SAMPLE_W-1:0] y_c;
  logic                       emit;

  always_comb begin
    case (ctrl_i.sel)
      SEL_HP1: begin
        coef_c     = hp1_coef_i;
        last_in_c  = s1_in_q;
        last_out_c = s1_out_q;
      end
      SEL_HP2: begin
        coef_c     = hp2_coef_i;
        last_in_c  = s2_in_q;
        last_out_c = s2_out_q;
      end
      default: begin
        coef_c     = lp_coef_i;
        last_in_c  = x_q;
        last_out_c = mem_q;
      end
    endcase
  end

  // High-pass operand is last_out + x - last_in. The low-pass is rewritten as
  // x * 2^16 + a * (mem - x), so it needs the same single multiply.
  always_comb begin
    if (ctrl_i.op == OP_DIFF) begin
      opnd_c = OPND_W'(mem_q) - OPND_W'(x_q);
    end else begin
      opnd_c = OPND_W'(last_out_c) + OPND_W'(x_q) - OPND_W'(last_in_c);
    end
  end

  assign coef_s = $signed({1'b0, coef_c});
  assign prod_c = coef_s * a_q;
  assign base_c = (ctrl_i.sel == SEL_LP) ? (PROD_W'(x_q) <<< FRAC_W) : '0;

  // Round half up, floor shift, then clamp to the sample range.
  always_comb begin
    rnd_c = p_q + ROUND_HALF;
    res_c = rnd_c[PROD_W-1:FRAC_W];
    if (res_c > RES_W'(SAT_MAX)) begin
      y_c = SAT_MAX;
    end else if (res_c < RES_W'(SAT_MIN)) begin
      y_c = SAT_MIN;
    end else begin
      y_c = res_c[SAMPLE_W-1:0];
    end
  end

  assign out_full_o = out_valid_q && out_stall_i;
  assign emit       = (ctrl_i.op == OP_EMIT) && !out_full_o;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= in_sample_i;
    end else if (ctrl_i.op == OP_RND) begin
      x_q <= y_c;
    end
    if (ctrl_i.op == OP_SUM || ctrl_i.op == OP_DIFF) begin
      a_q <= opnd_c;
    end
    if (ctrl_i.op == OP_MUL) begin
      p_q <= prod_c + base_c;
    end
    if (emit) begin
      out_q <= x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_in_q     <= '0;
      s1_out_q    <= '0;
      s2_in_q     <= '0;
      s2_out_q    <= '0;
      mem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_RND) begin
        case (ctrl_i.sel)
          SEL_HP1: begin
            s1_in_q  <= x_q;
            s1_out_q <= y_c;
          end
          SEL_HP2: begin
            s2_in_q  <= x_q;
            s2_out_q <= y_c;
          end
          default: begin
            mem_q <= y_c;
          end
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  a_emit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted result did not reach the output register");

  a_s1_only_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.op == OP_RND && ctrl_i.sel == SEL_HP1) |=> $stable(s1_out_q))
    else $error("first stage state changed outside its round step");

  a_mem_only_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.op == OP_RND && ctrl_i.sel == SEL_LP) |=> $stable(mem_q))
    else $error("low-pass memory changed outside its round step");

endmodule

// ----- rtl/dual_highpass_slew_lowpass_chain_unit.sv -----
// ----------------------------------------------------------------------------
// dual_highpass_slew_lowpass_chain_unit
// Two cascaded first-order high-pass stages and a one-pole low-pass on
// signed Q1.23 samples, run by a microcoded sequencer over one multiplier.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   input     in          in_valid_i/in_stall_o  in_sample_i   [23:0] signed
//   output    out         out_valid_o/out_stall_i out_sample_o [23:0] signed
//   config    in          cfg_valid_i/cfg_ready_o cfg_index_i [1:0], cfg_data_i [15:0]
//
// A sample is accepted only at the wait step, so one finishes before the next;
// the 12-step program sums, multiplies and rounds for each stage in turn on the
// shared 17x26 multiplier, three times per sample, then emits the result.
// Reset clears all filter state and loads the default coefficients.
// A stalled output holds the program at its emit step; input stays stalled.
// ----------------------------------------------------------------------------
module dual_highpass_slew_lowpass_chain_unit
  import dhslc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [COEF_W-1:0]          cfg_data_i
);

  ctrl_t             ctrl;
  status_t           status;
  logic              out_full;
  logic [COEF_W-1:0] hp1_coef_q, hp2_coef_q, lp_coef_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp1_coef_q <= HP1_COEF_RST;
      hp2_coef_q <= HP2_COEF_RST;
      lp_coef_q  <= LP_COEF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HP1_COEF: hp1_coef_q <= cfg_data_i;
        REG_HP2_COEF: hp2_coef_q <= cfg_data_i;
        REG_LP_COEF:  lp_coef_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o       = (ctrl.op != OP_LOAD);
  assign status.in_accept = in_valid_i && !in_stall_o;
  assign status.out_full  = out_full;

  dhslc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  dhslc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .load_i       (status.in_accept),
    .in_sample_i  (in_sample_i),
    .hp1_coef_i   (hp1_coef_q),
    .hp2_coef_i   (hp2_coef_q),
    .lp_coef_i    (lp_coef_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_full_o   (out_full),
    .out_sample_o (out_sample_o)
  );

endmodule

// ----- sim/dual_highpass_slew_lowpass_chain_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_highpass_slew_lowpass_chain_unit_tb
// Self-checking bench for the two-stage high-pass and slew low-pass chain.
// Samples stream in random bursts while the output stalls on its own
// pattern. Every accepted sample is run through a fixed-point model of the
// chain, and each output transaction is compared with the oldest prediction.
// Coefficients are reprogrammed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module dual_highpass_slew_lowpass_chain_unit_tb;
  import dhslc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic signed [SAMPLE_W-1:0] Q23_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] Q23_MIN = 24'sh800000;
  // The one index that maps to no coefficient.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] in_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [COEF_W-1:0]          cfg_data_i  = '0;

  dual_highpass_slew_lowpass_chain_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_sample_i (in_sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_sample_o(out_sample_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the coefficients and the filter memories.
  logic [COEF_W-1:0]          hp1_coef = HP1_COEF_RST;
  logic [COEF_W-1:0]          hp2_coef = HP2_COEF_RST;
  logic [COEF_W-1:0]          lp_coef  = LP_COEF_RST;
  logic signed [SAMPLE_W-1:0] hp1_in   = '0;
  logic signed [SAMPLE_W-1:0] hp1_out  = '0;
  logic signed [SAMPLE_W-1:0] hp2_in   = '0;
  logic signed [SAMPLE_W-1:0] hp2_out  = '0;
  logic signed [SAMPLE_W-1:0] lp_mem   = '0;

  logic signed [SAMPLE_W-1:0] sample_backlog[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];
  logic signed [SAMPLE_W-1:0] last_queued = '0;
  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 1;
  int gap_left    = 0;
  int stall_run   = 0;

  // Drops the 16 fraction bits with round half up, then clips to Q1.23.
  function automatic logic signed [SAMPLE_W-1:0] round_to_q23(input longint prod);
    longint q;
    q = (prod + 32768) >>> FRAC_W;
    if (q > longint'(Q23_MAX)) return Q23_MAX;
    if (q < longint'(Q23_MIN)) return Q23_MIN;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] x);
    longint diff;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
    diff = longint'(hp1_out) + longint'(x) - longint'(hp1_in);
    y1 = round_to_q23(longint'(hp1_coef) * diff);
    hp1_in  = x;
    hp1_out = y1;
    diff = longint'(hp2_out) + longint'(y1) - longint'(hp2_in);
    y2 = round_to_q23(longint'(hp2_coef) * diff);
    hp2_in  = y1;
    hp2_out = y2;
    lp_mem = round_to_q23(longint'(lp_coef) * longint'(lp_mem)
                          + (65536 - longint'(lp_coef)) * longint'(y2));
    return lp_mem;
  endfunction

  // Full-scale steps push the high-pass sums past the sample range.
  task automatic queue_directed();
    sample_backlog.push_back('0);
    sample_backlog.push_back(Q23_MAX);
    sample_backlog.push_back(Q23_MAX);
    sample_backlog.push_back(Q23_MIN);
    sample_backlog.push_back(Q23_MIN);
    sample_backlog.push_back(Q23_MAX);
    sample_backlog.push_back(Q23_MIN);
    sample_backlog.push_back(24'sd1);
    sample_backlog.push_back(-24'sd1);
    sample_backlog.push_back(24'sh400000);
    sample_backlog.push_back(24'shC00000);
    sample_backlog.push_back('0);
    last_queued = '0;
  endtask

  // Mix of full-range noise, quiet signal, rail hits and held values.
  task automatic queue_random(input int count);
    logic signed [SAMPLE_W-1:0] s;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s = 24'($urandom);
        4, 5:       s = 24'($urandom_range(0, 2047) - 1024);
        6:          s = $urandom_range(0, 1) ? Q23_MAX : Q23_MIN;
        default:    s = last_queued;
      endcase
      sample_backlog.push_back(s);
      last_queued = s;
    end
  endtask

  // Sampled at the falling edge, after every clocked update has settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_backlog.size() != 0 || in_valid_i || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Valid stays high across consecutive writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_coefs(input logic [COEF_W-1:0] hp1, input logic [COEF_W-1:0] hp2,
                               input logic [COEF_W-1:0] lp);
    write_reg(REG_HP1_COEF, hp1);
    write_reg(REG_HP2_COEF, hp2);
    write_reg(REG_LP_COEF, lp);
    // A write to the spare index must leave every coefficient alone.
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_sample_i <= '0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (sample_backlog.size() != 0) begin
        in_valid_i  <= 1'b1;
        in_sample_i <= sample_backlog.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random free and stalled runs, never two stalled runs in a row; some free runs long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall_i || $urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b0;
      stall_run   <= $urandom_range(0, 40);
    end else begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(0, 15);
    end
  end

  // Tracks coefficient writes, predicts on input transactions and checks
  // output transactions against the oldest prediction.
  always @(posedge clk_i) begin : check_output
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_HP1_COEF: hp1_coef = cfg_data_i;
          REG_HP2_COEF: hp2_coef = cfg_data_i;
          REG_LP_COEF:  lp_coef  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        expected_samples.push_back(filter_sample(in_sample_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $error("out_sample: unexpected output transaction, value %0d", out_sample_o);
          error_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_o !== want) begin
            $error("out_sample: expected %0d, got %0d", want, out_sample_o);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("dual_highpass_slew_lowpass_chain_unit: mismatch");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients.
    queue_directed();
    queue_random(230);
    wait_drained();

    // Zero coefficients: high-pass stages go silent, low-pass passes through.
    program_coefs('0, '0, '0);
    queue_directed();
    queue_random(230);
    wait_drained();

    program_coefs('1, '1, '1);
    queue_random(230);
    wait_drained();

    // Near-unity high-pass straight to the output exposes saturation.
    program_coefs('1, '1, '0);
    queue_random(230);
    wait_drained();

    for (int k = 0; k < 3; k++) begin
      program_coefs(16'($urandom), 16'($urandom), 16'($urandom));
      queue_random(230);
      wait_drained();
    end

    program_coefs(HP1_COEF_RST, HP2_COEF_RST, LP_COEF_RST);
    queue_random(230);
    wait_drained();

    if (error_count == 0 && expected_samples.size() == 0)
      $display("dual_highpass_slew_lowpass_chain_unit: match");
    else
      $display("dual_highpass_slew_lowpass_chain_unit: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dhslc_pkg.sv
rtl/dhslc_seq.sv
rtl/dhslc_dp.sv
rtl/dual_highpass_slew_lowpass_chain_unit.sv
sim/dual_highpass_slew_lowpass_chain_unit_tb.sv
